// ===== rtl/gost94_pkg.sv =====
// Shared types, constants and the round function for the GOST R 34.11-94 hash engine.
// Used by gost94_ctrl, gost94_dp and gost_94_hash_engine; depends on nothing.
`default_nettype none
package gost94_pkg;

  localparam int PsiPre   = 12;
  localparam int PsiTotal = 74;   // 12 + 1 + 61 shuffle steps
  localparam int RotBits  = 11;

  localparam logic [63:0] RC0 = 64'hff00ff00ff00ff00;
  localparam logic [63:0] RC1 = 64'h00ff00ff00ff00ff;
  localparam logic [63:0] RC2 = 64'hff0000ff00ffff00;
  localparam logic [63:0] RC3 = 64'hff00ffff000000ff;

  localparam logic [3:0] SBOX [128] = '{
    4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
    4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3,
    4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
    4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9,
    4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
    4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11,
    4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
    4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3,
    4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
    4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2,
    4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
    4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14,
    4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
    4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12,
    4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
    4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12
  };

  // Message source of one compression
  typedef enum logic [1:0] {
    SRC_BUF = 2'd0,
    SRC_LEN = 2'd1,
    SRC_SUM = 2'd2
  } src_t;

  typedef struct packed {
    logic       accept;   // input transaction taken this cycle
    logic       start;    // begin a compression
    src_t       src;
    logic [1:0] out_idx;  // hash word on the output
    logic       clear;    // message finished
  } cmd_t;

  typedef struct packed {
    logic done;       // compression finished, chaining value updated
    logic blk_full;   // this input word completes a block
    logic partial;    // words remain in the buffer after this input word
  } sts_t;

  // S-box substitution, then rotate left
  function automatic logic [31:0] round_f(input logic [31:0] x);
    logic [31:0] y;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX[{n[2:0], x[4*n +: 4]}];
    end
    return {y[31-RotBits:0], y[31:32-RotBits]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gost94_dp.sv =====
// Datapath: IV registers, block buffer, checksum, length and the iterated compression unit.
// Depends on gost94_pkg; driven by gost94_ctrl through cmd_t / sts_t.
`default_nettype none
module gost94_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gost94_pkg::cmd_t   cmd,
  output gost94_pkg::sts_t        sts,
  input  wire logic [63:0]        data_word,
  input  wire logic [3:0]         byte_count,
  input  wire logic               cfg_wr,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [63:0]        cfg_data,
  output logic [63:0]             cfg_rdata,
  output logic [63:0]             hash_word
);
  import gost94_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_PSI} cph_t;

  logic [3:0][63:0] iv, h, csum, buf_w, m, u, v, s;
  logic [63:0]      blen;
  logic [1:0]       wpos;
  logic             started;
  cph_t             cph;
  logic [31:0]      ra, rb;
  logic [4:0]       rcnt;
  logic [1:0]       blk;
  logic [255:0]     x;
  logic [6:0]       pcnt;
  logic             done;

  logic [3:0]       cnt;
  logic [63:0]      word_m;
  logic [3:0][63:0] buf_pad, src_val, w, u_next, v_next;
  logic [7:0][31:0] key;
  logic [2:0]       kidx;
  logic [31:0]      rk, fval, ra_next, rb_next;
  logic [255:0]     xx, x_next;
  logic [15:0]      t;

  // Clamp count and zero unused bytes
  always_comb begin
    cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
    for (int b = 0; b < 8; b++) begin
      word_m[8*b +: 8] = (4'(b) < cnt) ? data_word[8*b +: 8] : 8'h00;
    end
  end

  // Zero-pad a partial block; wpos of zero means a full block
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      buf_pad[k] = (wpos == 2'd0 || 2'(k) < wpos) ? buf_w[k] : 64'd0;
    end
    case (cmd.src)
      SRC_LEN: src_val = {128'd0, {61'd0, blen[63:61]}, {blen[60:0], 3'b000}};
      SRC_SUM: src_val = csum;
      default: src_val = buf_pad;
    endcase
  end

  // Round key from u xor v, one cipher round
  always_comb begin
    w = u ^ v;
    for (int j = 0; j < 8; j++) begin
      for (int q = 0; q < 4; q++) begin
        key[j][8*q +: 8] = w[q][8*j +: 8];
      end
    end
    kidx    = (rcnt[4:3] == 2'b11) ? ~rcnt[2:0] : rcnt[2:0];
    rk      = key[kidx];
    fval    = round_f((rcnt[0] ? rb : ra) + rk);
    ra_next = rcnt[0] ? (ra ^ fval) : ra;
    rb_next = rcnt[0] ? rb : (rb ^ fval);
    u_next  = {u[0] ^ u[1], u[3], u[2], u[1]};
    if (blk == 2'd1) begin
      u_next = u_next ^ {RC3, RC2, RC1, RC0};
    end
    v_next  = {v[1] ^ v[2], v[0] ^ v[1], v[3], v[2]};
  end

  // One psi step with key mixing on the two mixing steps
  always_comb begin
    xx = x;
    if (pcnt == 7'(PsiPre)) begin
      xx = xx ^ m;
    end
    if (pcnt == 7'(PsiPre + 1)) begin
      xx = xx ^ h;
    end
    t = xx[15:0] ^ xx[31:16] ^ xx[47:32] ^ xx[63:48] ^ xx[207:192] ^ xx[255:240];
    x_next = {t, xx[255:16]};
  end

  // Status to the controller
  always_comb begin
    sts.done     = done;
    sts.blk_full = (cnt != 4'd0) && (wpos == 2'd3);
    sts.partial  = (cnt != 4'd0) ? (wpos != 2'd3) : (wpos != 2'd0);
    cfg_rdata    = iv[cfg_idx];
    hash_word    = h[cmd.out_idx];
  end

  // Hold config, message state and the compression sequence
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      iv      <= '0;
      h       <= '0;
      csum    <= '0;
      blen    <= '0;
      wpos    <= '0;
      started <= 1'b0;
      cph     <= C_IDLE;
    end else begin
      if (cfg_wr) begin
        iv[cfg_idx] <= cfg_data;
      end
      if (cmd.accept) begin
        if (!started) begin
          h       <= iv;
          started <= 1'b1;
        end
        if (cnt != 4'd0) begin
          buf_w[wpos] <= word_m;
          wpos        <= wpos + 2'd1;
          blen        <= blen + {60'd0, cnt};
        end
      end
      if (cmd.start) begin
        m    <= src_val;
        u    <= h;
        v    <= src_val;
        ra   <= h[0][31:0];
        rb   <= h[0][63:32];
        rcnt <= '0;
        blk  <= '0;
        cph  <= C_ROUND;
        if (cmd.src == SRC_BUF) begin
          csum <= csum + buf_pad;
          wpos <= '0;
        end
      end
      unique case (cph)
        C_ROUND: begin
          rcnt <= rcnt + 5'd1;
          ra   <= ra_next;
          rb   <= rb_next;
          if (rcnt == 5'd31) begin
            s[blk] <= {ra_next, rb_next};
            if (blk == 2'd3) begin
              x    <= {ra_next, rb_next, s[2], s[1], s[0]};
              pcnt <= '0;
              cph  <= C_PSI;
            end else begin
              u   <= u_next;
              v   <= v_next;
              blk <= blk + 2'd1;
              ra  <= h[blk + 2'd1][31:0];
              rb  <= h[blk + 2'd1][63:32];
            end
          end
        end
        C_PSI: begin
          x    <= x_next;
          pcnt <= pcnt + 7'd1;
          if (pcnt == 7'(PsiTotal - 1)) begin
            h    <= x_next;
            done <= 1'b1;
            cph  <= C_IDLE;
          end
        end
        default: ;
      endcase
      if (cmd.clear) begin
        csum    <= '0;
        blen    <= '0;
        wpos    <= '0;
        started <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gost94_ctrl.sv =====
// Controller: sequences block, length and checksum compressions and the hash output.
// Depends on gost94_pkg; commands gost94_dp.
`default_nettype none
module gost94_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               last,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              word_index,
  output logic                    last_word,
  input  wire gost94_pkg::sts_t   sts,
  output gost94_pkg::cmd_t        cmd
);
  import gost94_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_OUT} state_t;

  state_t     state;
  src_t       src;
  logic       start;
  logic       last_q;
  logic [1:0] idx;
  logic       acc, out_fire;

  always_comb begin
    in_stall   = (state != S_IDLE);
    acc        = in_valid && !in_stall;
    out_valid  = (state == S_OUT);
    out_fire   = out_valid && !out_stall;
    word_index = idx;
    last_word  = (idx == 2'd3);
    cmd.accept  = acc;
    cmd.start   = start;
    cmd.src     = src;
    cmd.out_idx = idx;
    cmd.clear   = out_fire && (idx == 2'd3);
  end

  // Advance the message sequence
  always_ff @(posedge clk) begin
    start <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      src    <= SRC_BUF;
      last_q <= 1'b0;
      idx    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            last_q <= last;
            if (sts.blk_full || (last && sts.partial)) begin
              src   <= SRC_BUF;
              start <= 1'b1;
              state <= S_CMP;
            end else if (last) begin
              src   <= SRC_LEN;
              start <= 1'b1;
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (sts.done) begin
            unique case (src)
              SRC_BUF: begin
                if (last_q) begin
                  src   <= SRC_LEN;
                  start <= 1'b1;
                end else begin
                  state <= S_IDLE;
                end
              end
              SRC_LEN: begin
                src   <= SRC_SUM;
                start <= 1'b1;
              end
              default: begin
                idx   <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_fire) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gost_94_hash_engine.sv =====
// Top level of the GOST R 34.11-94 hash engine: APB register port plus controller and datapath.
// Depends on gost94_pkg, gost94_ctrl and gost94_dp.
//
// Feed a message as 64-bit little-endian words with a valid byte count and a last flag; four
// hash words (index 0..3) come out after the last word. Each full 256-bit block passes through
// one shared compression unit: 4 x 32 cipher rounds at one round per cycle, then 74 psi shuffle
// steps at one per cycle. A word that does not complete a block starts no compression, and the
// engine stays ready for the next word. The last word adds one padded block if the buffer
// is partial, then two more compressions (length and checksum) before the output. The start
// value is read from iv_word0..3 (byte addresses 0, 8, 16, 24) when a message begins; write
// them only while the engine is idle.
`default_nettype none
module gost_94_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      hash_word,
  output logic [1:0]       word_index,
  output logic             last_word
);
  import gost94_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  // Register write on the APB access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  gost94_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last       (last),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word),
    .sts        (sts),
    .cmd        (cmd)
  );

  gost94_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .data_word  (data_word),
    .byte_count (byte_count),
    .cfg_wr     (cfg_wr),
    .cfg_idx    (paddr[4:3]),
    .cfg_data   (pwdata),
    .cfg_rdata  (prdata),
    .hash_word  (hash_word)
  );

endmodule
`default_nettype wire

// ===== dv/gost94_checker.sv =====
// Checker for the GOST R 34.11-94 hash engine: watches both channels, predicts the hash words
// and compares them. Depends on gost94_pkg for the S-box table and round constants.
`timescale 1ns / 100ps
`default_nettype none
module gost94_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        iv_we,
  input  wire logic [1:0]  iv_sel,
  input  wire logic [63:0] iv_val,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] hash_word,
  input  wire logic [1:0]  word_index,
  input  wire logic        last_word,
  output int               fail_count,
  output int               pending
);
  import gost94_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        fin;
  } hash_out_t;

  hash_out_t   hash_q[$];
  logic [63:0] iv_m[4];
  logic [63:0] chain[4];
  logic [63:0] csum[4];
  logic [63:0] blk_buf[4];
  logic [63:0] nbytes;
  logic [1:0]  wpos;
  logic        open_msg;

  assign pending = hash_q.size();

  function automatic logic [31:0] sub_rot(input logic [31:0] x);
    logic [31:0] y;
    for (int n = 0; n < 8; n++) y[4*n +: 4] = SBOX[n*16 + x[4*n +: 4]];
    return {y[20:0], y[31:21]};
  endfunction

  function automatic logic [63:0] gost_encrypt(input logic [31:0] key[8], input logic [63:0] b);
    logic [31:0] a, c, k;
    a = b[31:0];
    c = b[63:32];
    for (int r = 0; r < 32; r++) begin
      k = (r < 24) ? key[r % 8] : key[7 - (r % 8)];
      if (r % 2 == 0) c ^= sub_rot(a + k);
      else a ^= sub_rot(c + k);
    end
    return {a, c};
  endfunction

  function automatic void psi(ref logic [15:0] x[16], input int cnt);
    logic [15:0] t;
    for (int c = 0; c < cnt; c++) begin
      t = x[0] ^ x[1] ^ x[2] ^ x[3] ^ x[12] ^ x[15];
      for (int i = 0; i < 15; i++) x[i] = x[i+1];
      x[15] = t;
    end
  endfunction

  // One step of the chaining function: chain <- f(chain, m)
  function automatic void step_hash(input logic [63:0] m[4]);
    logic [63:0] u[4], v[4], w[4], s[4], t;
    logic [63:0] rc[4];
    logic [31:0] key[8];
    logic [15:0] x[16];
    rc = '{RC0, RC1, RC2, RC3};
    u = chain;
    v = m;
    for (int i = 0; i < 4; i++) begin
      for (int q = 0; q < 4; q++) w[q] = u[q] ^ v[q];
      for (int j = 0; j < 8; j++)
        for (int q = 0; q < 4; q++) key[j][8*q +: 8] = w[q][8*j +: 8];
      s[i] = gost_encrypt(key, chain[i]);
      if (i == 3) break;
      t = u[0] ^ u[1]; u = '{u[1], u[2], u[3], t};
      if (i == 1) for (int q = 0; q < 4; q++) u[q] ^= rc[q];
      for (int r = 0; r < 2; r++) begin
        t = v[0] ^ v[1]; v = '{v[1], v[2], v[3], t};
      end
    end
    for (int i = 0; i < 16; i++) x[i] = s[i/4][16*(i%4) +: 16];
    psi(x, PsiPre);
    for (int i = 0; i < 16; i++) x[i] ^= m[i/4][16*(i%4) +: 16];
    psi(x, 1);
    for (int i = 0; i < 16; i++) x[i] ^= chain[i/4][16*(i%4) +: 16];
    psi(x, 61);
    for (int q = 0; q < 4; q++) chain[q] = {x[4*q+3], x[4*q+2], x[4*q+1], x[4*q]};
  endfunction

  function automatic void absorb_block();
    logic [64:0] acc;
    logic        cy;
    step_hash(blk_buf);
    cy = 0;
    for (int i = 0; i < 4; i++) begin
      acc = {1'b0, csum[i]} + {1'b0, blk_buf[i]} + cy;
      csum[i] = acc[63:0];
      cy = acc[64];
    end
    blk_buf = '{default: '0};
    wpos = 0;
  endfunction

  // Advance the message state by one input transaction
  function automatic void take_word(input logic [63:0] dw, input logic [3:0] bc,
                                    input logic lst);
    logic [3:0]  n;
    logic [63:0] wd, lenb[4];
    hash_out_t   h;
    n = (bc > 8) ? 4'd8 : bc;
    wd = dw;
    if (!open_msg) begin
      chain = iv_m;
      open_msg = 1;
    end
    if (n != 0) begin
      if (n < 8) wd &= (64'd1 << (8*n)) - 1;
      nbytes += n;
      blk_buf[wpos] = wd;
      wpos++;
      if (wpos == 0) absorb_block();
    end
    if (lst) begin
      if (wpos != 0) absorb_block();
      lenb = '{nbytes << 3, nbytes >> 61, 64'd0, 64'd0};
      step_hash(lenb);
      step_hash(csum);
      for (int k = 0; k < 4; k++) begin
        h.word = chain[k];
        h.idx = k;
        h.fin = (k == 3);
        hash_q.push_back(h);
      end
      csum = '{default: '0};
      blk_buf = '{default: '0};
      nbytes = 0;
      wpos = 0;
      open_msg = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Track config, predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    hash_out_t e;
    if (rst) begin
      iv_m = '{default: '0};
      chain = '{default: '0};
      csum = '{default: '0};
      blk_buf = '{default: '0};
      nbytes = 0;
      wpos = 0;
      open_msg = 0;
      fail_count = 0;
      hash_q.delete();
    end else begin
      if (iv_we) iv_m[iv_sel] = iv_val;
      if (in_valid && !in_stall) take_word(data_word, byte_count, last);
      if (out_valid && !out_stall) begin
        if (hash_q.size() == 0) begin
          report_mismatch("unexpected hash word", hash_word, 64'd0);
        end else begin
          e = hash_q.pop_front();
          if (hash_word !== e.word) report_mismatch("hash_word", hash_word, e.word);
          if (word_index !== e.idx) report_mismatch("word_index", word_index, e.idx);
          if (last_word !== e.fin) report_mismatch("last_word", last_word, e.fin);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for the GOST R 34.11-94 hash engine: clock, reset, APB writes and message
// stimulus. Depends on gost_94_hash_engine and gost94_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  logic [63:0] data_word = '0;
  logic [3:0]  byte_count = '0;
  logic        last = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [63:0] hash_word;
  logic [1:0]  word_index;
  logic        last_word;
  int          fail_count, pending;
  logic        calm = 0;   // no idling at all while set

  localparam int IvRegs = 4;

  gost_94_hash_engine dut (.*);

  gost94_checker chk (
    .clk, .rst,
    .iv_we(psel && penable && pwrite && pready), .iv_sel(paddr[4:3]), .iv_val(pwdata),
    .in_valid, .in_stall, .data_word, .byte_count, .last,
    .out_valid, .out_stall, .hash_word, .word_index, .last_word,
    .fail_count, .pending
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stall the output at random
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
  end

  task automatic write_iv(input int idx, input logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= idx * 8; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Present one input transaction and hold it until accepted; valid stays up for the next one
  task automatic send_word(input logic [63:0] dw, input logic [3:0] bc, input logic lst);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; data_word <= dw; byte_count <= bc; last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_msg(input int nwords, input int tail);
    for (int i = 0; i < nwords; i++)
      send_word({$urandom, $urandom}, (i == nwords - 1) ? tail[3:0] : 4'd8,
                i == nwords - 1);
  endtask

  // Drop valid, let the checker see the last transaction, then wait for all hash words
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: zero start value, extremes of fields
    send_word(64'd0, 4'd0, 1'b1);                       // empty message
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);    // count above eight
    send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);     // short word not last
    send_word(64'hfedc_ba98_7654_3210, 4'd0, 1'b0);     // zero count, not stored
    send_word(64'h5555_aaaa_5555_aaaa, 4'd8, 1'b1);
    send_msg(4, 8);                                     // exact block
    send_msg(4, 0);
    send_msg(5, 7);
    send_msg(8, 8);
    drain();
    // Extreme start value
    for (int i = 0; i < IvRegs; i++) write_iv(i, 64'hffff_ffff_ffff_ffff);
    send_word(64'd0, 4'd0, 1'b1);
    send_msg(3, 2);
    drain();
    // Random phases with random start values
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < IvRegs; i++) write_iv(i, {$urandom, $urandom});
      calm = (ph == 2);
      for (int m = 0; m < 10; m++) begin
        int nw;
        nw = $urandom_range(1, 9);
        for (int i = 0; i < nw; i++) begin
          logic lst;
          logic [3:0] bc;
          lst = (i == nw - 1);
          bc = ($urandom_range(9) == 0) ? $urandom_range(15) : (lst ? $urandom_range(8) : 4'd8);
          send_word({$urandom, $urandom}, bc, lst);
        end
      end
      calm = 0;
      drain();
    end
    for (int i = 0; i < IvRegs; i++) write_iv(i, 64'd0);
    send_msg(2, 5);
    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
